// ===== rtl/core/svpwm_duty_min_max_defines.svh =====
// assertion macros for the svpwm checker
`ifndef SVPWM_DUTY_MIN_MAX_DEFINES_SVH
`define SVPWM_DUTY_MIN_MAX_DEFINES_SVH

// clocked assertion, quiet while reset is asserted
`define SVPWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion that also runs through reset
`define SVPWM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/svpwm_pkg.sv =====
// shared types and constants of the svpwm duty generator
`default_nettype none

package svpwm_pkg;

    // field widths
    localparam int VIN_W  = 16;
    localparam int DUTY_W = 16;
    localparam int NPH    = 3;

    // internal datapath widths
    localparam int PROD_W = 34;  // beta times 2K
    localparam int PH_W   = 35;  // phase voltages in 2^-16 units
    localparam int SUM_W  = 36;  // max plus min
    localparam int Y_W    = 38;  // offset numerator
    localparam int NUM_W  = 33;  // divider numerator
    localparam int DEN_W  = 17;  // divider denominator, twice the bus voltage

    // sqrt(3)/2 in Q1.15, doubled
    localparam logic signed [17:0] SQRT3_Q15X2 = 18'sd56756;

    localparam logic [DUTY_W-1:0] DUTY_MID = 16'h8000;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 16'hFFFF;
    localparam logic [DUTY_W-1:0] DUTY_MIN = 16'h0000;

    typedef logic [DUTY_W-1:0] t_duty;
    typedef logic [NUM_W-1:0]  t_num;
    typedef logic [DEN_W-1:0]  t_den;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CLIP     = 2'd1,
        ST_BUS_ZERO = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/svpwm_div.sv =====
// pipelined restoring divider, three lanes sharing one denominator
`default_nettype none

module svpwm_div #(
    parameter int STEPS = 4
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  svpwm_pkg::t_den     i_den,
    input  svpwm_pkg::t_num     i_num [svpwm_pkg::NPH],
    output svpwm_pkg::t_duty    o_quo [svpwm_pkg::NPH]
);
    import svpwm_pkg::*;

    localparam int NSTG = DUTY_W / STEPS;

    logic [DEN_W-1:0]  r_rem [NSTG][NPH];
    logic [DUTY_W-1:0] r_rq  [NSTG][NPH];
    logic [DEN_W-1:0]  r_den [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [DEN_W-1:0]  in_rem [NPH];
        logic [DUTY_W-1:0] in_rq  [NPH];
        logic [DEN_W-1:0]  den_in;
        logic [DEN_W-1:0]  n_rem  [NPH];
        logic [DUTY_W-1:0] n_rq   [NPH];

        // stage input: fresh numerator or previous partial remainder
        if (s == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < NPH; l++) begin
                    in_rem[l] = i_num[l][NUM_W-1:DUTY_W];
                    in_rq[l]  = i_num[l][DUTY_W-1:0];
                end
                den_in = i_den;
            end
        end else begin : g_next
            always_comb begin
                for (int l = 0; l < NPH; l++) begin
                    in_rem[l] = r_rem[s-1][l];
                    in_rq[l]  = r_rq[s-1][l];
                end
                den_in = r_den[s-1];
            end
        end

        // per step, move one numerator bit into the remainder and one quotient bit into rq
        always_comb begin
            logic [DEN_W-1:0]  rem;
            logic [DUTY_W-1:0] rq;
            logic [DEN_W:0]    t;
            logic              ge;
            for (int l = 0; l < NPH; l++) begin
                rem = in_rem[l];
                rq  = in_rq[l];
                for (int j = 0; j < STEPS; j++) begin
                    t  = {rem, rq[DUTY_W-1]};
                    ge = (t >= {1'b0, den_in});
                    if (ge) begin
                        t = t - {1'b0, den_in};
                    end
                    rem = t[DEN_W-1:0];
                    rq  = {rq[DUTY_W-2:0], ge};
                end
                n_rem[l] = rem;
                n_rq[l]  = rq;
            end
        end

        // stage registers
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_rq[s]  <= n_rq;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_quo = r_rq[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/core/svpwm_duty_min_max.sv =====
// space vector pwm duty generator with min-max common mode injection
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_v_alpha, i_v_beta, i_bus_voltage
//   output   out        o_valid / i_stall  o_duty_phase_a/b/c, o_status
//
// one transaction per clock while no result is held at the output under i_stall
// the pipelined divider yields DIV_STEPS quotient bits per stage
// the whole pipeline freezes while a result waits at the output under i_stall
// synchronous active-low reset clears the valid bits only
`default_nettype none

module svpwm_duty_min_max #(
    parameter int DIV_STEPS = 4   // 1, 2, 4 or 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [svpwm_pkg::VIN_W-1:0]    i_v_alpha,
    input  logic signed [svpwm_pkg::VIN_W-1:0]    i_v_beta,
    input  logic        [svpwm_pkg::VIN_W-1:0]    i_bus_voltage,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic        [svpwm_pkg::DUTY_W-1:0]   o_duty_phase_a,
    output logic        [svpwm_pkg::DUTY_W-1:0]   o_duty_phase_b,
    output logic        [svpwm_pkg::DUTY_W-1:0]   o_duty_phase_c,
    output logic        [1:0]                     o_status
);
    import svpwm_pkg::*;

    localparam int DIV_STG = DUTY_W / DIV_STEPS;
    localparam int NS      = 5 + DIV_STG;

    logic          en;
    logic [NS-1:0] r_v;

    // pipeline control: everything moves unless the output is held
    assign en      = !(r_v[NS-1] && i_stall);
    assign o_stall = r_v[NS-1] && i_stall;
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // stage 1: beta times 2K
    logic signed [VIN_W-1:0]  r1_al;
    logic signed [PROD_W-1:0] r1_prod;
    logic        [VIN_W-1:0]  r1_vdc;
    logic signed [PROD_W-1:0] n1_prod;

    assign n1_prod = i_v_beta * SQRT3_Q15X2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_al   <= i_v_alpha;
            r1_prod <= n1_prod;
            r1_vdc  <= i_bus_voltage;
        end
    end

    // stage 2: rebuild the three phase voltages
    logic signed [PH_W-1:0]  r2_ph [NPH];
    logic        [VIN_W-1:0] r2_vdc;
    logic signed [PH_W-1:0]  n2_ph [NPH];
    logic signed [PH_W-1:0]  half_al;

    always_comb begin
        half_al  = PH_W'(signed'({r1_al, {(DUTY_W-1){1'b0}}}));
        n2_ph[0] = PH_W'(signed'({r1_al, {DUTY_W{1'b0}}}));
        n2_ph[1] = PH_W'(r1_prod) - half_al;
        n2_ph[2] = -half_al - PH_W'(r1_prod);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ph  <= n2_ph;
            r2_vdc <= r1_vdc;
        end
    end

    // stage 3: max plus min of the phases
    logic signed [PH_W-1:0]  r3_ph [NPH];
    logic signed [SUM_W-1:0] r3_s;
    logic        [VIN_W-1:0] r3_vdc;
    logic signed [PH_W-1:0]  mx;
    logic signed [PH_W-1:0]  mn;
    logic signed [SUM_W-1:0] n3_s;

    always_comb begin
        mx = (r2_ph[0] > r2_ph[1]) ? ((r2_ph[0] > r2_ph[2]) ? r2_ph[0] : r2_ph[2])
                                   : ((r2_ph[1] > r2_ph[2]) ? r2_ph[1] : r2_ph[2]);
        mn = (r2_ph[0] < r2_ph[1]) ? ((r2_ph[0] < r2_ph[2]) ? r2_ph[0] : r2_ph[2])
                                   : ((r2_ph[1] < r2_ph[2]) ? r2_ph[1] : r2_ph[2]);
        n3_s = SUM_W'(mx) + SUM_W'(mn);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ph  <= r2_ph;
            r3_s   <= n3_s;
            r3_vdc <= r2_vdc;
        end
    end

    // stage 4: numerator 2P - S with rounding and mid-scale offset folded in
    logic signed [Y_W-1:0]   r4_y [NPH];
    logic        [VIN_W-1:0] r4_vdc;
    logic                    r4_zero;
    logic signed [Y_W-1:0]   n4_y [NPH];
    logic signed [Y_W-1:0]   ofs;

    always_comb begin
        // bus voltage times 65537
        ofs = signed'(Y_W'({r3_vdc, r3_vdc}));
        for (int l = 0; l < NPH; l++) begin
            n4_y[l] = (Y_W'(r3_ph[l]) <<< 1) - Y_W'(r3_s) + ofs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_y    <= n4_y;
            r4_vdc  <= r3_vdc;
            r4_zero <= (r3_vdc == '0);
        end
    end

    // divider stages, saturation flags travel alongside
    t_num          div_num [NPH];
    t_duty         div_quo [NPH];
    logic [NPH-1:0] n_lo;
    logic [NPH-1:0] n_hi;
    logic [NPH-1:0] r_lo   [DIV_STG];
    logic [NPH-1:0] r_hi   [DIV_STG];
    logic           r_zero [DIV_STG];
    logic signed [Y_W-1:0] lim;

    always_comb begin
        lim = signed'(Y_W'({r4_vdc, {(DUTY_W+1){1'b0}}}));
        for (int l = 0; l < NPH; l++) begin
            div_num[l] = r4_y[l][NUM_W-1:0];
            n_lo[l]    = r4_y[l][Y_W-1];
            n_hi[l]    = (r4_y[l] >= lim);
        end
    end

    svpwm_div #(
        .STEPS (DIV_STEPS)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_den ({r4_vdc, 1'b0}),
        .i_num (div_num),
        .o_quo (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lo[0]   <= n_lo;
            r_hi[0]   <= n_hi & ~n_lo;
            r_zero[0] <= r4_zero;
            for (int s = 1; s < DIV_STG; s++) begin
                r_lo[s]   <= r_lo[s-1];
                r_hi[s]   <= r_hi[s-1];
                r_zero[s] <= r_zero[s-1];
            end
        end
    end

    // output stage: saturate, bus-zero override, status
    t_duty   r_duty [NPH];
    t_status r_status;
    t_duty   n_duty [NPH];
    t_status n_status;
    logic    clip;

    always_comb begin
        clip = |(r_lo[DIV_STG-1] | r_hi[DIV_STG-1]);
        for (int l = 0; l < NPH; l++) begin
            if (r_zero[DIV_STG-1]) begin
                n_duty[l] = DUTY_MID;
            end else if (r_lo[DIV_STG-1][l]) begin
                n_duty[l] = DUTY_MIN;
            end else if (r_hi[DIV_STG-1][l]) begin
                n_duty[l] = DUTY_MAX;
            end else begin
                n_duty[l] = div_quo[l];
            end
        end
        if (r_zero[DIV_STG-1]) begin
            n_status = ST_BUS_ZERO;
        end else if (clip) begin
            n_status = ST_CLIP;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_duty   <= n_duty;
            r_status <= n_status;
        end
    end

    assign o_duty_phase_a = r_duty[0];
    assign o_duty_phase_b = r_duty[1];
    assign o_duty_phase_c = r_duty[2];
    assign o_status       = r_status;

endmodule

`default_nettype wire

// ===== rtl/core/svpwm_checker.sv =====
// port-level checker for the svpwm duty generator, bound to the top level
`default_nettype none
`include "svpwm_duty_min_max_defines.svh"

module svpwm_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_stall,
    input  logic                                  o_valid,
    input  logic                                  i_stall,
    input  logic        [svpwm_pkg::DUTY_W-1:0]   o_duty_phase_a,
    input  logic        [svpwm_pkg::DUTY_W-1:0]   o_duty_phase_b,
    input  logic        [svpwm_pkg::DUTY_W-1:0]   o_duty_phase_c,
    input  logic        [1:0]                     o_status
);
    import svpwm_pkg::*;

    // reset empties the pipeline
    `SVPWM_ASSERT_RST(a_rst_clears_valid, !i_rst_n |=> !o_valid, "valid after reset")

    // input is only held back by a waiting result
    `SVPWM_ASSERT(a_empty_no_stall, !o_valid |-> !o_stall, "stall with empty output")

    // zero bus gives mid-scale on every phase
    `SVPWM_ASSERT(a_bus_zero_mid, (o_valid && o_status == ST_BUS_ZERO) |-> (o_duty_phase_a == DUTY_MID && o_duty_phase_b == DUTY_MID && o_duty_phase_c == DUTY_MID), "bus zero duty not mid")

    // a clip status implies some phase sits on a rail
    `SVPWM_ASSERT(a_clip_rail, (o_valid && o_status == ST_CLIP) |-> (o_duty_phase_a == DUTY_MIN || o_duty_phase_a == DUTY_MAX || o_duty_phase_b == DUTY_MIN || o_duty_phase_b == DUTY_MAX || o_duty_phase_c == DUTY_MIN || o_duty_phase_c == DUTY_MAX), "clip without rail")

    // a stalled transaction holds
    `SVPWM_ASSERT(a_out_hold, (o_valid && i_stall) |=> (o_valid && $stable(o_duty_phase_a) && $stable(o_duty_phase_b) && $stable(o_duty_phase_c) && $stable(o_status)), "stalled output moved")

endmodule

bind svpwm_duty_min_max svpwm_checker u_svpwm_checker (.*);

`default_nettype wire

// ===== dv/svpwm_duty_min_max_tb.sv =====
// self-checking testbench for the svpwm min-max duty generator
`default_nettype none

module svpwm_duty_min_max_tb;

    import svpwm_pkg::*;

    // sqrt(3)/2 in Q1.15, doubled: phase b and c get beta times this
    localparam longint SQRT3_X2 = 2 * 28378;
    localparam int RANDOM_VECS = 1080;
    localparam int DRAIN_CYCLES = 40;     // longer than the pipeline depth
    localparam int IDLE_LIMIT = 2000;     // cycles with no transaction on either side
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [VIN_W-1:0] alpha;
        logic signed [VIN_W-1:0] beta;
        logic [VIN_W-1:0]        vbus;
    } t_vec_item;

    typedef struct {
        t_duty   a;
        t_duty   b;
        t_duty   c;
        t_status st;
    } t_duty_set;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [VIN_W-1:0] i_v_alpha;
    logic signed [VIN_W-1:0] i_v_beta;
    logic [VIN_W-1:0]        i_bus_voltage;
    logic                    o_valid;
    logic                    i_stall;
    t_duty                   o_duty_phase_a;
    t_duty                   o_duty_phase_b;
    t_duty                   o_duty_phase_c;
    logic [1:0]              o_status;

    t_vec_item pending_vecs[$];
    t_duty_set expected_duties[$];

    logic vec_taken;
    int   vecs_sent;
    int   duties_checked;
    int   clip_count;
    int   bus_zero_count;
    int   mismatches;
    int   idle_cycles;

    svpwm_duty_min_max dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_v_alpha      (i_v_alpha),
        .i_v_beta       (i_v_beta),
        .i_bus_voltage  (i_bus_voltage),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_duty_phase_a (o_duty_phase_a),
        .o_duty_phase_b (o_duty_phase_b),
        .o_duty_phase_c (o_duty_phase_c),
        .o_status       (o_status)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one phase duty: offset, divide by twice the bus voltage rounding half up, saturate
    // bit 16 of the return value flags saturation
    function automatic logic [16:0] phase_duty(longint p, longint sum, longint vbus);
        longint num;
        longint den;
        longint q;
        num = 2 * (2 * p - sum) + 2 * vbus;
        den = 4 * vbus;
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        q = q + 32768;
        if (q < 0) begin
            return {1'b1, DUTY_MIN};
        end
        if (q > 65535) begin
            return {1'b1, DUTY_MAX};
        end
        return {1'b0, q[15:0]};
    endfunction

    // three phase duties with min-max common mode removed
    function automatic t_duty_set predict_duties(logic signed [VIN_W-1:0] alpha,
                                                 logic signed [VIN_W-1:0] beta,
                                                 logic [VIN_W-1:0] vbus);
        longint pa;
        longint pb;
        longint pc;
        longint hi;
        longint lo;
        logic [16:0] ra;
        logic [16:0] rb;
        logic [16:0] rc;
        t_duty_set r;
        if (vbus == 0) begin
            r.a = DUTY_MID;
            r.b = DUTY_MID;
            r.c = DUTY_MID;
            r.st = ST_BUS_ZERO;
            return r;
        end
        pa = longint'(alpha) * 65536;
        pb = -longint'(alpha) * 32768 + longint'(beta) * SQRT3_X2;
        pc = -longint'(alpha) * 32768 - longint'(beta) * SQRT3_X2;
        hi = (pa > pb) ? ((pa > pc) ? pa : pc) : ((pb > pc) ? pb : pc);
        lo = (pa < pb) ? ((pa < pc) ? pa : pc) : ((pb < pc) ? pb : pc);
        ra = phase_duty(pa, hi + lo, longint'(vbus));
        rb = phase_duty(pb, hi + lo, longint'(vbus));
        rc = phase_duty(pc, hi + lo, longint'(vbus));
        r.a = ra[15:0];
        r.b = rb[15:0];
        r.c = rc[15:0];
        r.st = (ra[16] || rb[16] || rc[16]) ? ST_CLIP : ST_OK;
        return r;
    endfunction

    // idle length: mostly none, some short, a few long; none at all in steady stretches
    function automatic int pick_idle(bit steady);
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    task automatic add_vec(int alpha, int beta, int vbus);
        t_vec_item v;
        v.alpha = VIN_W'(alpha);
        v.beta = VIN_W'(beta);
        v.vbus = VIN_W'(vbus);
        pending_vecs.push_back(v);
    endtask

    // input driver, changes on the falling edge
    int  src_gap = 0;
    bit  src_steady = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || vec_taken)) begin
            if (src_gap > 0) begin
                i_valid <= 1'b0;
                src_gap = src_gap - 1;
            end else if (pending_vecs.size() > 0) begin
                i_v_alpha <= pending_vecs[0].alpha;
                i_v_beta <= pending_vecs[0].beta;
                i_bus_voltage <= pending_vecs[0].vbus;
                i_valid <= 1'b1;
                void'(pending_vecs.pop_front());
                if ($urandom_range(99) < 3) begin
                    src_steady = !src_steady;
                end
                src_gap = pick_idle(src_steady);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    int  stall_left = 0;
    bit  sink_steady = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left = stall_left - 1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(99) < 2) begin
                    sink_steady = !sink_steady;
                end
                stall_left = pick_idle(sink_steady);
            end
        end
    end

    // monitor: check results, record accepted inputs, watchdog
    always @(posedge i_clk) begin
        t_duty_set want;
        if (!i_rst_n) begin
            vec_taken <= 1'b0;
        end else begin
            // output transaction against the oldest expectation
            if (o_valid && !i_stall) begin
                if (expected_duties.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result: a=%h b=%h c=%h status=%0d",
                                 o_duty_phase_a, o_duty_phase_b, o_duty_phase_c, o_status);
                    end
                end else begin
                    want = expected_duties.pop_front();
                    duties_checked = duties_checked + 1;
                    if (want.st == ST_CLIP) begin
                        clip_count = clip_count + 1;
                    end
                    if (want.st == ST_BUS_ZERO) begin
                        bus_zero_count = bus_zero_count + 1;
                    end
                    if (o_duty_phase_a !== want.a || o_duty_phase_b !== want.b ||
                        o_duty_phase_c !== want.c || o_status !== want.st) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch on result %0d: exp a=%h b=%h c=%h st=%0d",
                                     duties_checked, want.a, want.b, want.c, want.st);
                            $display("                      got a=%h b=%h c=%h st=%0d",
                                     o_duty_phase_a, o_duty_phase_b, o_duty_phase_c,
                                     o_status);
                        end
                    end
                end
            end

            // input transaction
            vec_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                expected_duties.push_back(predict_duties(i_v_alpha, i_v_beta, i_bus_voltage));
                vecs_sent = vecs_sent + 1;
            end

            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("svpwm_duty_min_max_tb NOT OK");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int r;
        int m;
        int vbus;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_v_alpha = '0;
        i_v_beta = '0;
        i_bus_voltage = '0;
        vec_taken = 1'b0;
        vecs_sent = 0;
        duties_checked = 0;
        clip_count = 0;
        bus_zero_count = 0;
        mismatches = 0;
        idle_cycles = 0;

        // directed: field extremes, zero bus, rounding ties, full duty, deep overmodulation
        add_vec(0, 0, 0);
        add_vec(32767, -32768, 0);
        add_vec(0, 0, 1);
        add_vec(0, 0, 65535);
        add_vec(32767, 0, 1);
        add_vec(-32768, 0, 1);
        add_vec(0, 32767, 1);
        add_vec(0, -32768, 1);
        add_vec(-32768, -32768, 65535);
        add_vec(32767, 32767, 65535);
        add_vec(-32768, 32767, 65535);
        add_vec(32767, -32768, 32768);
        add_vec(1, 0, 32768);       // phase a ties up, phase b and c tie negative
        add_vec(-1, 0, 32768);
        add_vec(2, 0, 3);           // phase a lands exactly on full duty
        add_vec(-2, 0, 3);
        add_vec(1, 0, 2);
        add_vec(0, 1, 1);
        add_vec(0, -1, 65535);
        add_vec(18918, 0, 32768);
        add_vec(0, 18918, 32768);
        add_vec(-12345, 23456, 40000);
        add_vec(-1, -1, 65534);

        // random: half the vectors bounded by half the bus voltage, plus full-range and corner noise
        for (int k = 0; k < RANDOM_VECS; k++) begin
            r = $urandom_range(99);
            if (r < 50) begin
                vbus = $urandom_range(65535, 1000);
                m = (vbus / 2 > 32767) ? 32767 : vbus / 2;
                add_vec(int'($urandom_range(2 * m)) - m, int'($urandom_range(2 * m)) - m, vbus);
            end else if (r < 80) begin
                add_vec($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
            end else if (r < 90) begin
                add_vec($urandom_range(65535), $urandom_range(65535), $urandom_range(16, 1));
            end else if (r < 94) begin
                add_vec($urandom_range(65535), $urandom_range(65535), 0);
            end else begin
                case ($urandom_range(3))
                    0: add_vec(32767, $urandom_range(1) ? 32767 : -32768, $urandom_range(65535));
                    1: add_vec(-32768, $urandom_range(65535), $urandom_range(1) ? 65535 : 1);
                    2: add_vec($urandom_range(1) ? 1 : -1, $urandom_range(1) ? 1 : -1,
                               $urandom_range(4, 1));
                    default: add_vec($urandom_range(65535), 0, $urandom_range(65535, 65500));
                endcase
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_vecs.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_duties.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d vectors, checked %0d duty sets (%0d clipped, %0d with zero bus)",
                 vecs_sent, duties_checked, clip_count, bus_zero_count);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_duties.size() == 0) begin
            $display("svpwm_duty_min_max_tb OK");
        end else begin
            $display("svpwm_duty_min_max_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
